// ===== rtl/core/spst_pkg.sv =====
// Shared constants, types and helper functions for the spring particle step block.
// Used by spst_sqrt, spst_div and the top level in rtl/core; no dependencies of its own.
`default_nettype none

package spst_pkg;

    localparam int PARTICLE_COUNT = 256;
    localparam int FRAC_BITS      = 16;
    localparam int ADDR_W         = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

    localparam int WORD_W   = 32;
    localparam int VEC_W    = 3 * WORD_W;

    // Square root unit: 64-bit radicand, one result bit per stage.
    localparam int SQ_IN_W     = 2 * WORD_W;
    localparam int SQ_ROOT_W   = WORD_W;
    localparam int SQRT_STAGES = SQ_ROOT_W;

    // Divider: quotient never exceeds the 31-bit speed limit.
    localparam int DIV_Q_W    = 31;
    localparam int DIV_D_W    = WORD_W;
    localparam int DIV_N_W    = DIV_Q_W + DIV_D_W;
    localparam int DIV_STAGES = DIV_Q_W;

    // Stage A through H, then the root, the scale multiply and the divider.
    localparam int PIPE_DEPTH = 8 + SQRT_STAGES + 1 + DIV_STAGES;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_K  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW    = 3'd5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic                   clamp;
        logic                   inrange;
        logic [2:0][WORD_W-1:0] pos;
        logic [2:0][WORD_W-1:0] vel;
    } side_t;

    localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
    localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

    function automatic word_t sat32(input logic signed [41:0] a);
        word_t r;
        if (a > SAT_MAX) begin
            r = word_t'(SAT_MAX[31:0]);
        end else if (a < SAT_MIN) begin
            r = word_t'(SAT_MIN[31:0]);
        end else begin
            r = word_t'(a[31:0]);
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mag32(input word_t v);
        logic [WORD_W-1:0] r;
        if (v < 0) begin
            r = WORD_W'(-v);
        end else begin
            r = WORD_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spst_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No package dependency.
`default_nettype none

module spst_ram #(
    parameter int WIDTH  = 96,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/spst_sqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
// Depends on spst_pkg for widths and stage count.
`default_nettype none

module spst_sqrt (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [spst_pkg::SQ_IN_W-1:0]  radicand,
    output logic      [spst_pkg::SQ_ROOT_W-1:0] root
);
    import spst_pkg::*;

    logic [SQ_IN_W-1:0]   n_reg    [SQRT_STAGES];
    logic [SQ_ROOT_W+2:0] rem_reg  [SQRT_STAGES];
    logic [SQ_ROOT_W-1:0] root_reg [SQRT_STAGES];

    logic [SQ_IN_W-1:0]   in_n    [SQRT_STAGES];
    logic [SQ_ROOT_W+2:0] in_rem  [SQRT_STAGES];
    logic [SQ_ROOT_W-1:0] in_root [SQRT_STAGES];

    logic [SQ_IN_W-1:0]   n_next    [SQRT_STAGES];
    logic [SQ_ROOT_W+2:0] rem_next  [SQRT_STAGES];
    logic [SQ_ROOT_W-1:0] root_next [SQRT_STAGES];

    always_comb
    begin
        in_n[0]    = radicand;
        in_rem[0]  = '0;
        in_root[0] = '0;
        for (int s = 1; s < SQRT_STAGES; s++)
        begin
            in_n[s]    = n_reg[s-1];
            in_rem[s]  = rem_reg[s-1];
            in_root[s] = root_reg[s-1];
        end
    end

    // The partial remainder stays below twice the partial root, so its top
    // two bits are free before the next pair of radicand bits shifts in.
    always_comb
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            logic [SQ_ROOT_W+2:0] rem2;
            logic [SQ_ROOT_W+2:0] trial;
            rem2  = {in_rem[s][SQ_ROOT_W:0], in_n[s][SQ_IN_W-1 -: 2]};
            trial = {1'b0, in_root[s], 2'b01};
            n_next[s] = {in_n[s][SQ_IN_W-3:0], 2'b00};
            if (rem2 >= trial)
            begin
                rem_next[s]  = rem2 - trial;
                root_next[s] = {in_root[s][SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem2;
                root_next[s] = {in_root[s][SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < SQRT_STAGES; s++)
            begin
                n_reg[s]    <= n_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/spst_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on spst_pkg; the caller guarantees the quotient fits DIV_Q_W bits.
`default_nettype none

module spst_div (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [spst_pkg::DIV_N_W-1:0] numer,
    input  wire logic [spst_pkg::DIV_D_W-1:0] denom,
    output logic      [spst_pkg::DIV_Q_W-1:0] quot
);
    import spst_pkg::*;

    logic [DIV_D_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_Q_W-1:0] lo_reg  [DIV_STAGES];
    logic [DIV_Q_W-1:0] q_reg   [DIV_STAGES];
    logic [DIV_D_W-1:0] den_reg [DIV_STAGES];

    logic [DIV_D_W-1:0] in_rem [DIV_STAGES];
    logic [DIV_Q_W-1:0] in_lo  [DIV_STAGES];
    logic [DIV_Q_W-1:0] in_q   [DIV_STAGES];
    logic [DIV_D_W-1:0] in_den [DIV_STAGES];

    logic [DIV_D_W-1:0] rem_next [DIV_STAGES];
    logic [DIV_Q_W-1:0] lo_next  [DIV_STAGES];
    logic [DIV_Q_W-1:0] q_next   [DIV_STAGES];

    always_comb
    begin
        in_rem[0] = numer[DIV_N_W-1 -: DIV_D_W];
        in_lo[0]  = numer[DIV_Q_W-1:0];
        in_q[0]   = '0;
        in_den[0] = denom;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            in_rem[s] = rem_reg[s-1];
            in_lo[s]  = lo_reg[s-1];
            in_q[s]   = q_reg[s-1];
            in_den[s] = den_reg[s-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            logic [DIV_D_W:0] r2;
            r2 = {in_rem[s], in_lo[s][DIV_Q_W-1]};
            lo_next[s] = {in_lo[s][DIV_Q_W-2:0], 1'b0};
            if (r2 >= {1'b0, in_den[s]})
            begin
                rem_next[s] = DIV_D_W'(r2 - {1'b0, in_den[s]});
                q_next[s]   = {in_q[s][DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = r2[DIV_D_W-1:0];
                q_next[s]   = {in_q[s][DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                lo_reg[s]  <= lo_next[s];
                q_reg[s]   <= q_next[s];
                den_reg[s] <= in_den[s];
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/spring_particle_step_top.sv =====
// Top level of the spring particle step block: particle RAMs, the update
// pipeline, the speed limiter and the output register.
// Depends on spst_pkg, spst_ram, spst_sqrt and spst_div.
//
// Usage:
//   The request channel (req_valid / req_stall) carries one word per item:
//   a load (action 0) writes a particle's position and velocity, a step
//   (action 1) advances it by dt. Every item returns exactly one result word
//   on the response channel (rsp_valid / rsp_stall) with the display
//   position (x, -z, y) and the clamped flag, in the order items came in.
//   Configuration registers are written through cfg_valid / cfg_ready,
//   which is always ready; write them only while the block is idle.
//
//   The request stage loads at acceptance, followed by seven more arithmetic
//   stages, 32 square root stages, one scale multiply and 31 divider stages,
//   then the output register, which raises rsp_valid. Throughput is one
//   item per cycle while req_stall is low. The particle RAM is read when an
//   item enters and written when it leaves, so an item whose index matches
//   one still in the pipeline is held off (req_stall) until that item has
//   written back; for distinct indices nothing waits.
//
//   Reset clears the pipeline valids and sets the registers to their
//   defaults; particle contents are undefined until loaded. When the
//   receiver stalls, the result holds in the output register, the pipeline
//   keeps closing up bubbles behind it and only freezes once its last stage
//   also holds a finished word.
`default_nettype none

module spring_particle_step_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [spst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                  cfg_data,

    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic                         action,
    input  wire logic [7:0]                   index,
    input  wire logic [15:0]                  dt,
    input  wire logic signed [31:0]           px,
    input  wire logic signed [31:0]           py,
    input  wire logic signed [31:0]           pz,
    input  wire logic signed [31:0]           vx,
    input  wire logic signed [31:0]           vy,
    input  wire logic signed [31:0]           vz,

    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic signed [31:0]                disp_x,
    output logic signed [31:0]                disp_y,
    output logic signed [31:0]                disp_z,
    output logic                              clamped
);
    import spst_pkg::*;

    localparam logic signed [47:0] HALF48 = 48'sd1 <<< (FRAC_BITS - 1);
    localparam logic [35:0]        HALF36 = 36'd1 << (FRAC_BITS - 1);
    localparam logic signed [55:0] HALF56 = 56'sd1 <<< (FRAC_BITS - 1);
    localparam int LAST = PIPE_DEPTH - 1;

    // Configuration registers.
    word_t       light_reg [3];
    logic [19:0] spring_k_reg;
    logic [30:0] max_speed_reg;
    logic        follow_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg[0]  <= '0;
            light_reg[1]  <= '0;
            light_reg[2]  <= '0;
            spring_k_reg  <= 20'd19661;
            max_speed_reg <= 31'd655360;
            follow_reg    <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LIGHT_X:   light_reg[0]  <= cfg_data;
                CFG_LIGHT_Y:   light_reg[1]  <= cfg_data;
                CFG_LIGHT_Z:   light_reg[2]  <= cfg_data;
                CFG_SPRING_K:  spring_k_reg  <= cfg_data[19:0];
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[30:0];
                CFG_FOLLOW:    follow_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Pipeline control. One valid bit and index per stage, used both as the
    // stage valids and for the read-after-write interlock on the RAM.
    logic       trk_valid_reg [PIPE_DEPTH];
    logic [7:0] trk_idx_reg   [PIPE_DEPTH];
    logic       adv;
    logic       hazard;
    logic       accept;
    logic       last_valid;
    logic       rsp_valid_reg;

    assign last_valid = trk_valid_reg[LAST];
    assign adv        = !(rsp_valid_reg && rsp_stall && last_valid);

    always_comb
    begin
        hazard = 1'b0;
        for (int j = 0; j < PIPE_DEPTH; j++)
        begin
            if (trk_valid_reg[j] && (trk_idx_reg[j] == index))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign req_stall = !adv || hazard;
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < PIPE_DEPTH; j++)
            begin
                trk_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            trk_valid_reg[0] <= accept;
            for (int j = 1; j < PIPE_DEPTH; j++)
            begin
                trk_valid_reg[j] <= trk_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trk_idx_reg[0] <= index;
            for (int j = 1; j < PIPE_DEPTH; j++)
            begin
                trk_idx_reg[j] <= trk_idx_reg[j-1];
            end
        end
    end

    // Particle RAMs, position and velocity, each holding {z, y, x}.
    logic [VEC_W-1:0] pos_rd;
    logic [VEC_W-1:0] vel_rd;
    logic             wr_en;
    logic [VEC_W-1:0] pos_wr;
    logic [VEC_W-1:0] vel_wr;
    side_t            fin_side;

    assign wr_en = adv && last_valid && fin_side.inrange;

    spst_ram #(.WIDTH(VEC_W), .DEPTH(PARTICLE_COUNT), .ADDR_W(ADDR_W)) u_pos_ram (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (ADDR_W'(index)),
        .rd_data (pos_rd),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(trk_idx_reg[LAST])),
        .wr_data (pos_wr)
    );

    spst_ram #(.WIDTH(VEC_W), .DEPTH(PARTICLE_COUNT), .ADDR_W(ADDR_W)) u_vel_ram (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (ADDR_W'(index)),
        .rd_data (vel_rd),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(trk_idx_reg[LAST])),
        .wr_data (vel_wr)
    );

    // Stage A: the request word, alongside the RAM read.
    logic        a_action_reg;
    logic        a_inrange_reg;
    logic [15:0] a_dt_reg;
    word_t       a_p_reg   [3];
    word_t       a_vin_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_action_reg  <= action;
            a_inrange_reg <= (17'(index) < 17'(PARTICLE_COUNT));
            a_dt_reg      <= dt;
            a_p_reg[0]    <= px;
            a_p_reg[1]    <= py;
            a_p_reg[2]    <= pz;
            a_vin_reg[0]  <= vx;
            a_vin_reg[1]  <= vy;
            a_vin_reg[2]  <= vz;
        end
    end

    // Stage B: v*dt for the position move and k*dt for the spring gain.
    logic                b_action_reg;
    logic                b_inrange_reg;
    logic signed [47:0]  b_prod_reg [3];
    logic [35:0]         b_kdp_reg;
    word_t               b_x_reg    [3];
    word_t               b_v_reg    [3];
    word_t               b_p_reg    [3];
    word_t               b_vin_reg  [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_action_reg  <= a_action_reg;
            b_inrange_reg <= a_inrange_reg;
            b_kdp_reg     <= spring_k_reg * a_dt_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_x_reg[i]    <= pos_rd[i*WORD_W +: WORD_W];
                b_v_reg[i]    <= vel_rd[i*WORD_W +: WORD_W];
                b_prod_reg[i] <= $signed(vel_rd[i*WORD_W +: WORD_W]) * $signed({1'b0, a_dt_reg});
                b_p_reg[i]    <= a_p_reg[i];
                b_vin_reg[i]  <= a_vin_reg[i];
            end
        end
    end

    // Stage C: moved (or followed, or loaded) position, and the rounded gain.
    logic        c_action_reg;
    logic        c_inrange_reg;
    word_t       c_x_reg [3];
    word_t       c_v_reg [3];
    logic [19:0] c_kd_reg;
    word_t       c_x_next [3];
    word_t       c_v_next [3];
    logic [35:0] kd_sum;

    always_comb
    begin
        kd_sum = b_kdp_reg + HALF36;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [47:0] moved;
            moved = (b_prod_reg[i] + HALF48) >>> FRAC_BITS;
            if (b_action_reg == ACT_LOAD)
            begin
                c_x_next[i] = b_p_reg[i];
                c_v_next[i] = b_vin_reg[i];
            end
            else
            begin
                c_v_next[i] = b_v_reg[i];
                if (follow_reg)
                begin
                    c_x_next[i] = b_p_reg[i];
                end
                else
                begin
                    c_x_next[i] = sat32(42'(b_x_reg[i]) + 42'(moved));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_action_reg  <= b_action_reg;
            c_inrange_reg <= b_inrange_reg;
            c_kd_reg      <= kd_sum[FRAC_BITS +: 20];
            for (int i = 0; i < 3; i++)
            begin
                c_x_reg[i] <= c_x_next[i];
                c_v_reg[i] <= c_v_next[i];
            end
        end
    end

    // Stage D: the exact spring offset 2x - light.
    logic               d_action_reg;
    logic               d_inrange_reg;
    word_t              d_x_reg    [3];
    word_t              d_v_reg    [3];
    logic [19:0]        d_kd_reg;
    logic signed [33:0] d_diff_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_action_reg  <= c_action_reg;
            d_inrange_reg <= c_inrange_reg;
            d_kd_reg      <= c_kd_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_x_reg[i]    <= c_x_reg[i];
                d_v_reg[i]    <= c_v_reg[i];
                d_diff_reg[i] <= $signed({c_x_reg[i][31], c_x_reg[i], 1'b0})
                                 - 34'(light_reg[i]);
            end
        end
    end

    // Stage E: gain times offset.
    logic               e_action_reg;
    logic               e_inrange_reg;
    word_t              e_x_reg    [3];
    word_t              e_v_reg    [3];
    logic signed [55:0] e_prod_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_action_reg  <= d_action_reg;
            e_inrange_reg <= d_inrange_reg;
            for (int i = 0; i < 3; i++)
            begin
                e_x_reg[i]    <= d_x_reg[i];
                e_v_reg[i]    <= d_v_reg[i];
                e_prod_reg[i] <= $signed({1'b0, d_kd_reg}) * d_diff_reg[i];
            end
        end
    end

    // Stage F: velocity after the spring pull.
    logic  f_action_reg;
    logic  f_inrange_reg;
    word_t f_x_reg  [3];
    word_t f_v_reg  [3];
    word_t f_v_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [55:0] pull;
            pull = (e_prod_reg[i] + HALF56) >>> FRAC_BITS;
            if (e_action_reg == ACT_LOAD)
            begin
                f_v_next[i] = e_v_reg[i];
            end
            else
            begin
                f_v_next[i] = sat32(42'(e_v_reg[i]) - 42'(pull));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_action_reg  <= e_action_reg;
            f_inrange_reg <= e_inrange_reg;
            for (int i = 0; i < 3; i++)
            begin
                f_x_reg[i] <= e_x_reg[i];
                f_v_reg[i] <= f_v_next[i];
            end
        end
    end

    // Stage G: component squares and the squared limit.
    logic        g_action_reg;
    logic        g_inrange_reg;
    word_t       g_x_reg  [3];
    word_t       g_v_reg  [3];
    logic [63:0] g_sq_reg [3];
    logic [61:0] g_lim2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_action_reg  <= f_action_reg;
            g_inrange_reg <= f_inrange_reg;
            g_lim2_reg    <= max_speed_reg * max_speed_reg;
            for (int i = 0; i < 3; i++)
            begin
                g_x_reg[i]  <= f_x_reg[i];
                g_v_reg[i]  <= f_v_reg[i];
                g_sq_reg[i] <= mag32(f_v_reg[i]) * mag32(f_v_reg[i]);
            end
        end
    end

    // Stage H: squared speed and the limit test.
    logic [63:0] h_s_reg;
    side_t       h_side_reg;
    logic [63:0] h_s_next;

    assign h_s_next = g_sq_reg[0] + g_sq_reg[1] + g_sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_s_reg            <= h_s_next;
            h_side_reg.clamp   <= (g_action_reg == ACT_STEP) && (h_s_next > 64'(g_lim2_reg));
            h_side_reg.inrange <= g_inrange_reg;
            for (int i = 0; i < 3; i++)
            begin
                h_side_reg.pos[i] <= g_x_reg[i];
                h_side_reg.vel[i] <= g_v_reg[i];
            end
        end
    end

    // Speed magnitude, with the item carried alongside.
    logic [SQ_ROOT_W-1:0] len;
    side_t                sq_side_reg [SQRT_STAGES];

    spst_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (h_s_reg),
        .root     (len)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= h_side_reg;
            for (int s = 1; s < SQRT_STAGES; s++)
            begin
                sq_side_reg[s] <= sq_side_reg[s-1];
            end
        end
    end

    // Stage M: |v| * max_speed for each component.
    side_t              m_side_reg;
    logic [DIV_N_W-1:0] m_num_reg [3];
    logic [DIV_D_W-1:0] m_len_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_side_reg <= sq_side_reg[SQRT_STAGES-1];
            m_len_reg  <= len;
            for (int i = 0; i < 3; i++)
            begin
                m_num_reg[i] <= mag32(word_t'(sq_side_reg[SQRT_STAGES-1].vel[i]))
                                * max_speed_reg;
            end
        end
    end

    // Rescale by division through the length; |v| never exceeds it, so the
    // quotient stays within the speed limit.
    logic [DIV_Q_W-1:0] quot [3];
    side_t              dv_side_reg [DIV_STAGES];

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        spst_div u_div (
            .clk   (clk),
            .en    (adv),
            .numer (m_num_reg[g]),
            .denom (m_len_reg),
            .quot  (quot[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= m_side_reg;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                dv_side_reg[s] <= dv_side_reg[s-1];
            end
        end
    end

    // Final velocity and position, written back as the word leaves.
    word_t fin_v [3];
    word_t fin_x [3];

    assign fin_side = dv_side_reg[DIV_STAGES-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            word_t vv;
            vv       = word_t'(fin_side.vel[i]);
            fin_x[i] = word_t'(fin_side.pos[i]);
            if (fin_side.clamp)
            begin
                if (vv < 0)
                begin
                    fin_v[i] = -word_t'({1'b0, quot[i]});
                end
                else
                begin
                    fin_v[i] = word_t'({1'b0, quot[i]});
                end
            end
            else
            begin
                fin_v[i] = vv;
            end
        end
    end

    assign pos_wr = {fin_x[2], fin_x[1], fin_x[0]};
    assign vel_wr = {fin_v[2], fin_v[1], fin_v[0]};

    // Output register.
    word_t disp_x_reg;
    word_t disp_y_reg;
    word_t disp_z_reg;
    logic  clamped_reg;
    word_t neg_z;

    assign neg_z = (fin_x[2] == word_t'(SAT_MIN[31:0])) ? word_t'(SAT_MAX[31:0]) : -fin_x[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || !rsp_stall)
        begin
            rsp_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!rsp_valid_reg || !rsp_stall)
        begin
            if (fin_side.inrange)
            begin
                disp_x_reg  <= fin_x[0];
                disp_y_reg  <= neg_z;
                disp_z_reg  <= fin_x[1];
                clamped_reg <= fin_side.clamp;
            end
            else
            begin
                disp_x_reg  <= '0;
                disp_y_reg  <= '0;
                disp_z_reg  <= '0;
                clamped_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign disp_x    = disp_x_reg;
    assign disp_y    = disp_y_reg;
    assign disp_z    = disp_z_reg;
    assign clamped   = clamped_reg;

endmodule

`default_nettype wire

// ===== test/spring_particle_step_top_tb.sv =====
// Testbench for spring_particle_step_top: directed and random load/step words
// checked against an in-bench fixed-point particle predictor.
// Depends on spst_pkg and the spring_particle_step_top RTL only.
`default_nettype none

module spring_particle_step_top_tb;

    import spst_pkg::*;

    // Clock, reset and all block inputs. Every input is driven from time zero.
    logic clk = 1'b0;
    logic rst_n;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    logic                 req_valid;
    logic                 req_stall;
    logic                 action;
    logic [7:0]           index;
    logic [15:0]          dt;
    logic signed [31:0]   px, py, pz, vx, vy, vz;

    logic                 rsp_valid;
    logic                 rsp_stall;
    logic signed [31:0]   disp_x, disp_y, disp_z;
    logic                 clamped;

    spring_particle_step_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .action    (action),
        .index     (index),
        .dt        (dt),
        .px        (px),
        .py        (py),
        .pz        (pz),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .disp_x    (disp_x),
        .disp_y    (disp_y),
        .disp_z    (disp_z),
        .clamped   (clamped)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // One expected result word: the display position and the clamp flag.
    typedef struct {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic               cl;
    } disp_word_t;

    disp_word_t expected_disp_q[$];
    int         error_count = 0;
    int         cycle_count = 0;

    // Quiet disables random idling on both sides for a stretch of the run.
    bit quiet = 1'b0;

    // Predictor copy of the registers and of the particle table.
    longint          lt_q[3];
    longint unsigned k_q;
    longint unsigned vmax_q;
    bit              follow_q;
    longint          pos_tab[3][256];
    longint          vel_tab[3][256];
    bit              loaded[256];

    function automatic longint clip32(input longint a);
        longint r;
        if (a > 64'sd2147483647) begin
            r = 64'sd2147483647;
        end else if (a < -64'sd2147483648) begin
            r = -64'sd2147483648;
        end else begin
            r = a;
        end
        return r;
    endfunction

    // Round to nearest at the 16 fraction bits; ties go up, shift floors.
    function automatic longint round_q(input longint a);
        return (a + 64'sd32768) >>> 16;
    endfunction

    function automatic longint unsigned magn(input longint a);
        longint unsigned r;
        if (a < 0) begin
            r = longint'(0) - a;
        end else begin
            r = a;
        end
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Apply one load or step word to the particle table and return its display word.
    function automatic disp_word_t advance_particle(input logic act, input logic [7:0] id,
                                                    input logic [15:0] dtv,
                                                    input longint p0, input longint p1,
                                                    input longint p2, input longint v0,
                                                    input longint v1, input longint v2);
        longint          x[3];
        longint          v[3];
        longint          pp[3];
        longint          kd;
        longint unsigned s;
        longint unsigned lim2;
        longint unsigned len;
        longint unsigned m;
        disp_word_t      r;
        pp[0] = p0;
        pp[1] = p1;
        pp[2] = p2;
        r.cl = 1'b0;
        if (act == ACT_LOAD) begin
            x = pp;
            v[0] = v0;
            v[1] = v1;
            v[2] = v2;
        end else begin
            s = 0;
            lim2 = vmax_q * vmax_q;
            for (int i = 0; i < 3; i++) begin
                x[i] = clip32(pos_tab[i][id] + round_q(vel_tab[i][id] * longint'(dtv)));
                v[i] = vel_tab[i][id];
            end
            if (follow_q) begin
                x = pp;
            end
            kd = round_q(longint'(k_q * dtv));
            for (int i = 0; i < 3; i++) begin
                v[i] = clip32(v[i] - round_q(kd * (2 * x[i] - lt_q[i])));
                s = s + magn(v[i]) * magn(v[i]);
            end
            // Over the limit: scale each component by max/|v|, truncating magnitudes.
            if (s > lim2) begin
                len = int_sqrt(s);
                r.cl = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    m = magn(v[i]) * vmax_q / len;
                    v[i] = (v[i] < 0) ? -longint'(m) : longint'(m);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            pos_tab[i][id] = x[i];
            vel_tab[i][id] = v[i];
        end
        loaded[id] = 1'b1;
        r.dx = x[0];
        r.dy = clip32(-x[2]);
        r.dz = x[1];
        return r;
    endfunction

    function automatic bit take_gap();
        return !quiet && ($urandom_range(99) < 17);
    endfunction

    // Response side: random stall, and each accepted word checked against the oldest expectation.
    always @(posedge clk)
    begin
        disp_word_t e;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_disp_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h %h %h %b",
                         $time, disp_x, disp_y, disp_z, clamped);
                error_count++;
            end else begin
                e = expected_disp_q.pop_front();
                if (disp_x !== e.dx) begin
                    $display("%0t: disp_x expected %h actual %h", $time, e.dx, disp_x);
                    error_count++;
                end
                if (disp_y !== e.dy) begin
                    $display("%0t: disp_y expected %h actual %h", $time, e.dy, disp_y);
                    error_count++;
                end
                if (disp_z !== e.dz) begin
                    $display("%0t: disp_z expected %h actual %h", $time, e.dz, disp_z);
                    error_count++;
                end
                if (clamped !== e.cl) begin
                    $display("%0t: clamped expected %b actual %b", $time, e.cl, clamped);
                    error_count++;
                end
            end
        end
        rsp_stall <= take_gap();
    end

    // Watchdog: far above the slowest legal run, including index hold-offs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 1000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Send one request word and record its expectation once accepted. Valid stays
    // high on return unless an idle gap follows, so back-to-back words do not toggle it.
    task automatic send_item(input logic act, input logic [7:0] id, input logic [15:0] dtv,
                             input logic [31:0] p0, input logic [31:0] p1,
                             input logic [31:0] p2, input logic [31:0] v0,
                             input logic [31:0] v1, input logic [31:0] v2);
        disp_word_t w;
        req_valid <= 1'b1;
        action    <= act;
        index     <= id;
        dt        <= dtv;
        px        <= p0;
        py        <= p1;
        pz        <= p2;
        vx        <= v0;
        vy        <= v1;
        vz        <= v2;
        do begin
            @(posedge clk);
        end while (req_stall);
        w = advance_particle(act, id, dtv,
            longint'($signed(p0)), longint'($signed(p1)), longint'($signed(p2)),
            longint'($signed(v0)), longint'($signed(v1)), longint'($signed(v2)));
        expected_disp_q.insert(expected_disp_q.size(), w);
        if (take_gap()) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Let every outstanding word come back, then give the pipeline its latency again.
    task automatic drain();
        req_valid <= 1'b0;
        while (expected_disp_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
    endtask

    // Valid stays high on return; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= d;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        case (ri)
            CFG_LIGHT_X:   lt_q[0] = longint'($signed(d));
            CFG_LIGHT_Y:   lt_q[1] = longint'($signed(d));
            CFG_LIGHT_Z:   lt_q[2] = longint'($signed(d));
            CFG_SPRING_K:  k_q = d[19:0];
            CFG_MAX_SPEED: vmax_q = d[30:0];
            CFG_FOLLOW:    follow_q = d[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] lx, input logic [31:0] ly,
                             input logic [31:0] lz, input logic [31:0] k,
                             input logic [31:0] vm, input logic [31:0] fm);
        write_reg(CFG_LIGHT_X, lx);
        write_reg(CFG_LIGHT_Y, ly);
        write_reg(CFG_LIGHT_Z, lz);
        write_reg(CFG_SPRING_K, k);
        write_reg(CFG_MAX_SPEED, vm);
        write_reg(CFG_FOLLOW, fm);
        cfg_valid <= 1'b0;
    endtask

    // Operand values: full range, small, near extremes and mid-sized magnitudes.
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(3))
            0: w = $urandom;
            1: w = $urandom_range(2097152) - 1048576;
            2: begin
                case ($urandom_range(3))
                    0: w = 32'h7fffffff;
                    1: w = 32'h80000000;
                    2: w = 32'h0;
                    default: w = 32'hffffffff;
                endcase
            end
            default: w = $urandom_range(33554432) - 16777216;
        endcase
        return w;
    endfunction

    // Mostly steps on loaded particles; loads fill in and refresh entries.
    // A step never targets an entry that was never loaded.
    task automatic run_random(input int n);
        logic [7:0]  id;
        logic [15:0] dtv;
        bit          any;
        for (int c = 0; c < n; c++) begin
            id = $urandom_range(255);
            dtv = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096));
            any = loaded[id];
            if (!any || $urandom_range(99) < 25) begin
                send_item(ACT_LOAD, id, dtv, rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word(), rand_word());
            end else begin
                send_item(ACT_STEP, id, dtv, rand_word(), rand_word(), rand_word(),
                          $urandom, $urandom, $urandom);
            end
        end
    endtask

    // Defaults after reset: load and step a few particles without writing any register.
    task automatic test_reset_defaults();
        send_item(ACT_LOAD, 8'd0, 16'd0, 32'h00010000, 32'h00020000, 32'hfffd0000,
                  32'h00008000, 32'hffff0000, 32'h00030000);
        send_item(ACT_STEP, 8'd0, 16'd1092, 32'h00004000, 32'h0, 32'hffffc000, 0, 0, 0);
        send_item(ACT_LOAD, 8'd255, 16'hffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_item(ACT_STEP, 8'd255, 16'hffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'hffffffff, 32'hffffffff, 32'hffffffff);
        drain();
    endtask

    // Extremes of the fields and registers: free motion, zero dt, saturating
    // position and velocity, zero and full speed limits, negated minimum z.
    task automatic test_directed_extremes();
        write_all(32'h7fffffff, 32'h80000000, 32'h0, 32'h000fffff, 32'h7fffffff, 32'h0);
        send_item(ACT_LOAD, 8'd1, 16'd0, 32'h7fff0000, 32'h80010000, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'h00100000);
        send_item(ACT_STEP, 8'd1, 16'hffff, 0, 0, 0, 0, 0, 0);
        send_item(ACT_STEP, 8'd1, 16'd0, 0, 0, 0, 0, 0, 0);
        send_item(ACT_LOAD, 8'd2, 16'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(ACT_STEP, 8'd2, 16'd32768, 32'h12345678, 0, 0, 0, 0, 0);
        drain();
        write_all(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0, 32'h0, 32'h1);
        send_item(ACT_STEP, 8'd1, 16'd100, 32'h00010000, 32'h0, 32'h80000000, 0, 0, 0);
        send_item(ACT_STEP, 8'd2, 16'd100, 32'h0, 32'h0, 32'h0, 0, 0, 0);
        send_item(ACT_LOAD, 8'd3, 16'd5, 32'h1, 32'hffffffff, 32'h7fffffff,
                  32'h00020000, 32'h0, 32'hfffe0000);
        send_item(ACT_STEP, 8'd3, 16'hffff, 32'hfffffffe, 32'h1, 32'h80000001, 0, 0, 0);
        drain();
        write_all(32'h0, 32'h0, 32'h0, 32'h000fffff, 32'h1, 32'h1);
        send_item(ACT_STEP, 8'd3, 16'hffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  0, 0, 0);
        send_item(ACT_STEP, 8'd1, 16'd1, 32'h00008000, 32'hffff8000, 32'h0, 0, 0, 0);
        drain();
    endtask

    task automatic test_random_default();
        write_all(32'h0, 32'h0, 32'h0, 32'd19661, 32'd655360, 32'h1);
        run_random(170);
        drain();
    endtask

    task automatic test_random_free_motion();
        write_all($urandom, $urandom, $urandom, $urandom_range(1048575),
                  $urandom_range(32'h7fffffff), 32'h0);
        run_random(170);
        drain();
    endtask

    // A long stretch with no idling on either side, and a zero speed limit.
    task automatic test_random_no_idle();
        quiet = 1'b1;
        write_all(rand_word(), rand_word(), rand_word(), 32'h000fffff, 32'h0, 32'h1);
        run_random(170);
        drain();
        quiet = 1'b0;
    endtask

    task automatic test_random_mixed();
        write_all(rand_word(), rand_word(), rand_word(), $urandom, $urandom, $urandom);
        run_random(170);
        drain();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        action    <= ACT_LOAD;
        index     <= '0;
        dt        <= '0;
        px        <= '0;
        py        <= '0;
        pz        <= '0;
        vx        <= '0;
        vy        <= '0;
        vz        <= '0;
        rsp_stall <= 1'b0;
        lt_q[0] = 0;
        lt_q[1] = 0;
        lt_q[2] = 0;
        k_q = 19661;
        vmax_q = 655360;
        follow_q = 1'b1;
        for (int i = 0; i < 256; i++) begin
            loaded[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_random_default();
        test_random_free_motion();
        test_random_no_idle();
        test_random_mixed();

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== spring_particle_step_top.f =====
rtl/core/spst_pkg.sv
rtl/core/spst_ram.sv
rtl/core/spst_sqrt.sv
rtl/core/spst_div.sv
rtl/core/spring_particle_step_top.sv
test/spring_particle_step_top_tb.sv
